### rtl/bba_pkg.sv
// Shared types and fixed constants of the buddy block allocator.
// No dependencies; bba_div, the allocator and its testbench import this package.
package bba_pkg;

	// Divider operand widths; the dividend width also holds size plus padding below 2^33
	localparam int DIV_DW = 33;
	localparam int DIV_VW = 17;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] request_bytes;
		logic [16:0] align_bytes;
		logic [9:0]  free_offset_units;
		logic [3:0]  free_order;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [9:0]  block_offset_units;
		logic [3:0]  block_order;
		logic [17:0] aligned_byte_offset;
		logic [18:0] total_allocated_bytes;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_PAD_GO,
		S_PAD_WAIT,
		S_SIZE,
		S_ORDER,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_MUL,
		S_ALN_GO,
		S_ALN_WAIT,
		S_FREE_CHK,
		S_FREE_RD,
		S_FREE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_VW-1:0] rem;
	} div_rsp_t;

endpackage

### rtl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/bba_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on bba_pkg for operand widths and command/result structs.
module bba_div import bba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t cmd,
	output div_rsp_t res
);

	localparam int CW = $clog2(DIV_DW + 1);

	logic [DIV_DW-1:0] quot_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   trial;
	logic [DIV_VW:0]   diff;
	logic              fits;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quot_q[DIV_DW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in and keep the partial remainder
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quot_q <= cmd.dividend;
			rem_q  <= '0;
			dvs_q  <= cmd.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_DW-2:0], fits};
			rem_q  <= fits ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

	a_no_restart : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_pulse : assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !res.done)
		else $error("divider done held longer than one cycle");

	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");

endmodule

### rtl/buddy_block_allocator.sv
// Buddy allocator over one pool of MIN_BLOCK_BYTES << MAX_ORDER bytes. One request
// is worked at a time; req_stall is high from acceptance until the result is staged
// in the output register, which can hold one finished beat while the next request is
// taken. After reset a clearing pass over the 2^(MAX_ORDER+1)/32 rows of the free map
// (64 at defaults, one row per cycle) runs first. The block's pace is set by one shared
// bit-serial divider, a compare loop for the order and the walk of the free-bit RAM:
// an allocate runs a division for the padding test and one for the alignment round-up
// when align_bytes is nonzero, forms the padded size, grows the order (size against
// MIN_BLOCK_BYTES << order), reads and checks each RAM row scanned and reads and
// writes each split level; a free checks the request, then reads and writes per level.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int MIN_BLOCK_BYTES = 256,
	parameter int MAX_ORDER       = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_item,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_item
);

	localparam int NW   = MAX_ORDER + 1;
	localparam int UW   = MAX_ORDER;
	localparam int OW   = $clog2(MAX_ORDER + 2);
	localparam int RBW  = (NW >= 5) ? 32 : (1 << NW);
	localparam int LB   = $clog2(RBW);
	localparam int ROWS = (1 << NW) / RBW;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [63:0] POOL_BYTES = 64'(MIN_BLOCK_BYTES) << MAX_ORDER;
	// Unchecked double frees can push the total past the pool; every map node counts once
	localparam int TW   = $clog2(64'(MAX_ORDER + 1) * POOL_BYTES + 64'd1);
	localparam int MW   = UW + DIV_VW;

	function automatic logic [RAW-1:0] row_of(input logic [NW-1:0] node);
		return RAW'(node >> LB);
	endfunction

	function automatic logic [LB-1:0] bit_of(input logic [NW-1:0] node);
		return node[LB-1:0];
	endfunction

	state_t            state_q, state_d;
	logic [RAW-1:0]    clr_q;
	logic [TW-1:0]     total_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	rsp_t              res_q;
	req_t              req_q;
	logic              pad_q;
	logic [DIV_DW-1:0] size_q;
	logic [OW-1:0]     order_q;
	logic [OW-1:0]     j_q;
	logic [RAW-1:0]    row_q;
	logic [NW-1:0]     node_q;
	logic [UW-1:0]     off_q;
	logic [DIV_DW-1:0] byte_q;

	logic              wr_en, rd_en;
	logic [RAW-1:0]    wr_addr, rd_addr;
	logic [RBW-1:0]    wr_data, rd_data;
	div_req_t          div_cmd;
	div_rsp_t          div_res;

	logic [NW-1:0]     n_cur;
	logic [NW:0]       nx;
	logic [RBW-1:0]    mask, sel;
	logic [LB-1:0]     lsb;
	logic              hit;
	logic [RAW-1:0]    row_last, row_next_j, row_first_ord;
	logic [NW-1:0]     found_node, split_tgt, buddy;
	logic              bud_free, merge;
	logic [3:0]        free_k;
	logic              free_ok;
	logic [NW-1:0]     free_node;
	logic              grow, fail_pre;
	logic [TW-1:0]     blk_bytes, free_bytes;
	logic [DIV_DW-1:0] byte_full;
	rsp_t              alloc_res, free_res, rsp_d;

	bba_ram #(.WIDTH(RBW), .DEPTH(ROWS)) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	// Derived search, split and merge values
	always_comb begin
		n_cur = NW'(1) << (OW'(MAX_ORDER) - j_q);
		nx    = {1'b0, n_cur};
		for (int b = 0; b < RBW; b++) begin
			mask[b] = (nx >= (NW+1)'(RBW)) ||
				(((NW+1)'(b) >= nx) && ((NW+1)'(b) < (nx << 1)));
		end
		sel = rd_data & mask;
		hit = |sel;
		lsb = '0;
		for (int b = RBW - 1; b >= 0; b--) begin
			if (sel[b]) begin
				lsb = LB'(b);
			end
		end
		row_last      = row_of((n_cur << 1) - NW'(1));
		row_next_j    = row_of(n_cur >> 1);
		row_first_ord = row_of(NW'(1) << (OW'(MAX_ORDER) - order_q));
		found_node    = NW'({row_q, lsb});
		split_tgt     = {node_q[NW-2:0], 1'b1};
		buddy         = node_q ^ NW'(1);
		bud_free      = rd_data[bit_of(buddy)];
		merge         = (order_q < OW'(MAX_ORDER)) && bud_free;
		free_k        = req_q.free_order;
		free_ok       = (32'(free_k) <= MAX_ORDER) &&
			({7'b0, req_q.free_offset_units} < (17'(1) << MAX_ORDER)) &&
			((req_q.free_offset_units & 10'((16'(1) << free_k) - 16'(1))) == 10'd0);
		free_node     = (NW'(1) << (OW'(MAX_ORDER) - OW'(free_k))) +
			NW'(req_q.free_offset_units >> free_k);
		// Grow while a block of this order is still smaller than the padded size
		grow          = (order_q <= OW'(MAX_ORDER)) &&
			((DIV_DW'(MIN_BLOCK_BYTES) << order_q) < size_q);
		fail_pre      = (total_q == TW'(POOL_BYTES)) || (order_q > OW'(MAX_ORDER));
		blk_bytes     = TW'(MIN_BLOCK_BYTES) << order_q;
		free_bytes    = TW'(MIN_BLOCK_BYTES) << free_k;
		byte_full     = DIV_DW'(MW'(off_q) * MW'(MIN_BLOCK_BYTES));

		alloc_res                     = '0;
		alloc_res.ok                  = 1'b1;
		alloc_res.block_offset_units  = 10'(off_q);
		alloc_res.block_order         = 4'(order_q);
		alloc_res.aligned_byte_offset = 18'(byte_full);

		free_res    = '0;
		free_res.ok = free_ok;

		rsp_d                       = res_q;
		rsp_d.total_allocated_bytes = 19'(total_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == RAW'(ROWS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					if (req_item.opcode == OP_FREE) state_d = S_FREE_CHK;
					else if (req_item.align_bytes != '0) state_d = S_PAD_GO;
					else state_d = S_SIZE;
				end
			end
			S_PAD_GO:    state_d = S_PAD_WAIT;
			S_PAD_WAIT:  if (div_res.done) state_d = S_SIZE;
			S_SIZE:      state_d = S_ORDER;
			S_ORDER: begin
				if (!grow) state_d = fail_pre ? S_DONE : S_SRCH_RD;
			end
			S_SRCH_RD:   state_d = S_SRCH_CHK;
			S_SRCH_CHK: begin
				if (hit) state_d = (j_q > order_q) ? S_SPLIT_RD : S_MUL;
				else if (row_q != row_last || j_q != OW'(MAX_ORDER)) state_d = S_SRCH_RD;
				else state_d = S_DONE;
			end
			S_SPLIT_RD:  state_d = S_SPLIT_WR;
			S_SPLIT_WR:  state_d = (j_q > order_q) ? S_SPLIT_RD : S_MUL;
			S_MUL:       state_d = (req_q.align_bytes != '0) ? S_ALN_GO : S_DONE;
			S_ALN_GO:    state_d = S_ALN_WAIT;
			S_ALN_WAIT:  if (div_res.done) state_d = S_DONE;
			S_FREE_CHK:  state_d = free_ok ? S_FREE_RD : S_DONE;
			S_FREE_RD:   state_d = S_FREE_WR;
			S_FREE_WR:   state_d = merge ? S_FREE_RD : S_DONE;
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// RAM and divider controls
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = row_q;
		div_cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q == '0) ? RBW'(2) : '0;
			end
			S_PAD_GO: begin
				div_cmd.start    = 1'b1;
				div_cmd.dividend = DIV_DW'(MIN_BLOCK_BYTES);
				div_cmd.divisor  = req_q.align_bytes;
			end
			S_ALN_GO: begin
				div_cmd.start    = 1'b1;
				div_cmd.dividend = byte_q;
				div_cmd.divisor  = req_q.align_bytes;
			end
			S_SRCH_RD: rd_en = 1'b1;
			S_SRCH_CHK: begin
				wr_en   = hit;
				wr_data = rd_data & ~(RBW'(1) << lsb);
			end
			S_SPLIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = row_of(split_tgt);
			end
			S_SPLIT_WR: begin
				wr_en   = 1'b1;
				wr_addr = row_of(node_q);
				wr_data = rd_data | (RBW'(1) << bit_of(node_q | NW'(1)));
			end
			S_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = row_of(node_q);
			end
			S_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = row_of(node_q);
				wr_data = merge ? (rd_data & ~(RBW'(1) << bit_of(buddy))) :
					(rd_data | (RBW'(1) << bit_of(node_q)));
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + RAW'(1);
			if (state_q == S_MUL) total_q <= total_q + blk_bytes;
			if (state_q == S_FREE_CHK && free_ok) begin
				total_q <= (total_q > free_bytes) ? total_q - free_bytes : '0;
			end
			// Stage a finished beat or drop the one taken downstream
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_q <= req_item;
					pad_q <= 1'b0;
				end
			end
			S_PAD_WAIT: begin
				if (div_res.done) pad_q <= div_res.rem != '0;
			end
			S_SIZE: begin
				size_q  <= DIV_DW'(req_q.request_bytes) +
					(pad_q ? DIV_DW'(req_q.align_bytes) : '0);
				order_q <= '0;
			end
			S_ORDER: begin
				if (grow) order_q <= order_q + OW'(1);
				else begin
					j_q   <= order_q;
					row_q <= row_first_ord;
					res_q <= '0;
				end
			end
			S_SRCH_CHK: begin
				if (hit) begin
					node_q <= found_node;
					off_q  <= UW'(NW'(found_node - n_cur) << j_q);
				end else if (row_q != row_last) begin
					row_q <= row_q + RAW'(1);
				end else if (j_q != OW'(MAX_ORDER)) begin
					j_q   <= j_q + OW'(1);
					row_q <= row_next_j;
				end
			end
			S_SPLIT_RD: begin
				node_q <= {node_q[NW-2:0], 1'b0};
				j_q    <= j_q - OW'(1);
			end
			S_MUL: begin
				byte_q <= byte_full;
				res_q  <= alloc_res;
			end
			S_ALN_WAIT: begin
				if (div_res.done && div_res.rem != '0) begin
					res_q.aligned_byte_offset <= 18'(byte_q +
						DIV_DW'(req_q.align_bytes) - DIV_DW'(div_res.rem));
				end
			end
			S_FREE_CHK: begin
				res_q   <= free_res;
				node_q  <= free_node;
				order_q <= OW'(free_k);
			end
			S_FREE_WR: begin
				if (merge) begin
					node_q  <= node_q >> 1;
					order_q <= order_q + OW'(1);
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q <= rsp_d;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	a_fail_zero : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.ok |-> rsp_item.block_offset_units == '0 &&
			rsp_item.block_order == '0 && rsp_item.aligned_byte_offset == '0)
		else $error("failed beat carries a nonzero block");

	a_ram_collide : assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("free map read and written in one cycle");

	a_done_stages : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && state_d == S_IDLE |=> rsp_valid_q)
		else $error("finished item left no result beat");

endmodule

### test/buddy_block_allocator_tb.sv
// Self-checking testbench for buddy_block_allocator: random and directed allocate/free
// beats, a behavioral buddy predictor and an in-order result scoreboard.
// Depends on bba_pkg and the RTL of buddy_block_allocator.
module buddy_block_allocator_tb import bba_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MIN_BYTES = 256;
	localparam int TOP_ORDER = 10;
	localparam int POOL_UNITS = 1 << TOP_ORDER;
	localparam longint POOL_BYTES = longint'(POOL_UNITS) * MIN_BYTES;
	localparam int NODES = 2 << TOP_ORDER;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_item;

	buddy_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
	);

	always #1 clk = ~clk;

	// Predictor state: free bit per tree node and running byte total
	bit free_bits[NODES];
	longint used_bytes;
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int send_idle_pct = 10;
	int recv_idle_pct = 81;
	bit stim_done = 1'b0;
	bit req_taken = 1'b0;
	longint cycles = 0;
	// Live blocks, kept so most frees hit something real
	int live_off[$];
	int live_ord[$];

	function automatic int node_idx(int k, int off);
		return (POOL_UNITS >> k) + (off >> k);
	endfunction

	function automatic rsp_t predict_buddy(req_t r);
		rsp_t o;
		longint size, units, boff, bytes;
		int order, j, i, n, off, k;
		bit found;
		o = '0;
		if (r.opcode == OP_ALLOC) begin
			size = r.request_bytes;
			if (r.align_bytes != 0 && (MIN_BYTES % r.align_bytes) != 0)
				size += r.align_bytes;
			units = (size + MIN_BYTES - 1) / MIN_BYTES;
			if (units == 0)
				units = 1;
			order = 0;
			while (order <= TOP_ORDER && (longint'(1) << order) < units)
				order++;
			if (used_bytes == POOL_BYTES || order > TOP_ORDER) begin
				o.total_allocated_bytes = used_bytes[18:0];
				return o;
			end
			found = 1'b0;
			off = 0;
			for (j = order; j <= TOP_ORDER && !found; j++) begin
				n = POOL_UNITS >> j;
				for (i = 0; i < n && !found; i++)
					if (free_bits[n + i]) begin
						found = 1'b1;
						off = i << j;
					end
				if (found)
					break;
			end
			if (!found) begin
				o.total_allocated_bytes = used_bytes[18:0];
				return o;
			end
			free_bits[node_idx(j, off)] = 1'b0;
			while (j > order) begin
				j--;
				free_bits[node_idx(j, off + (1 << j))] = 1'b1;
			end
			used_bytes += (longint'(1) << order) * MIN_BYTES;
			boff = longint'(off) * MIN_BYTES;
			if (r.align_bytes != 0 && (boff % r.align_bytes) != 0)
				boff = (boff / r.align_bytes + 1) * r.align_bytes;
			o.ok = 1'b1;
			o.block_offset_units = off[9:0];
			o.block_order = order[3:0];
			o.aligned_byte_offset = boff[17:0];
			o.total_allocated_bytes = used_bytes[18:0];
			live_off = {live_off, off};
			live_ord = {live_ord, order};
		end else begin
			off = r.free_offset_units;
			k = r.free_order;
			if (k > TOP_ORDER || off >= POOL_UNITS || (off & ((1 << k) - 1)) != 0) begin
				o.total_allocated_bytes = used_bytes[18:0];
				return o;
			end
			bytes = (longint'(1) << k) * MIN_BYTES;
			// Merge upward while the buddy is free
			forever begin
				if (k == TOP_ORDER) begin
					free_bits[node_idx(k, off)] = 1'b1;
					break;
				end
				if (free_bits[node_idx(k, off ^ (1 << k))]) begin
					free_bits[node_idx(k, off ^ (1 << k))] = 1'b0;
					off = off & ~(1 << k);
					k++;
				end else begin
					free_bits[node_idx(k, off)] = 1'b1;
					break;
				end
			end
			used_bytes = (used_bytes > bytes) ? used_bytes - bytes : 0;
			o.ok = 1'b1;
			o.total_allocated_bytes = used_bytes[18:0];
		end
		return o;
	endfunction

	function automatic req_t make_alloc(longint sz, int al);
		req_t r;
		r = '0;
		r.opcode = OP_ALLOC;
		r.request_bytes = sz[31:0];
		r.align_bytes = al[16:0];
		r.free_offset_units = 10'($urandom);
		r.free_order = 4'($urandom);
		return r;
	endfunction

	function automatic req_t make_free(int off, int ord);
		req_t r;
		r = '0;
		r.opcode = OP_FREE;
		r.request_bytes = $urandom;
		r.align_bytes = 17'($urandom);
		r.free_offset_units = off[9:0];
		r.free_order = ord[3:0];
		return r;
	endfunction

	// Queue a beat and work out its result right away; results come in order
	task automatic queue_beat(req_t r);
		pending_reqs = {pending_reqs, r};
		expected_rsps = {expected_rsps, predict_buddy(r)};
	endtask

	// Random allocate with mostly small sizes and assorted alignments
	function automatic req_t rand_alloc();
		longint sz;
		int al;
		case ($urandom_range(0, 9))
			0: sz = $urandom;
			1: sz = $urandom_range(0, 262144);
			2, 3: sz = $urandom_range(0, 16384);
			default: sz = $urandom_range(0, 2048);
		endcase
		case ($urandom_range(0, 5))
			0: al = 0;
			1: al = 1 << $urandom_range(0, 16);
			2: al = $urandom_range(0, 131071);
			3: al = 65536;
			default: al = $urandom_range(0, 700);
		endcase
		return make_alloc(sz, al);
	endfunction

	function automatic req_t rand_free();
		int idx;
		int off, ord;
		if (live_off.size() > 0 && $urandom_range(0, 9) < 8) begin
			idx = $urandom_range(0, live_off.size() - 1);
			off = live_off[idx];
			ord = live_ord[idx];
			live_off.delete(idx);
			live_ord.delete(idx);
			return make_free(off, ord);
		end
		return make_free($urandom_range(0, 1023), $urandom_range(0, 15));
	endfunction

	// Stimulus: directed beats then three random phases of differing idle mix
	initial begin
		int ph, i;
		used_bytes = 0;
		foreach (free_bits[n])
			free_bits[n] = 1'b0;
		free_bits[node_idx(TOP_ORDER, 0)] = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_beat(make_alloc(0, 0));
		queue_beat(make_alloc(1, 1));
		queue_beat(make_alloc(256, 256));
		queue_beat(make_alloc(257, 3));
		queue_beat(make_alloc(300, 65536));
		queue_beat(make_alloc(1000, 131071));
		queue_beat(make_alloc(32'hFFFF_FFFF, 0));
		queue_beat(make_alloc(32'hFFFF_FFFF, 131071));
		queue_beat(make_alloc(262145, 0));
		queue_beat(make_free(1023, 0));
		queue_beat(make_free(0, 11));
		queue_beat(make_free(3, 2));
		queue_beat(make_free(0, 15));
		while (live_off.size() > 0)
			queue_beat(rand_free());
		queue_beat(make_free(0, 10));
		queue_beat(make_alloc(262144, 0));
		queue_beat(make_alloc(1, 0));
		queue_beat(make_free(0, 10));
		queue_beat(make_free(0, 10));
		queue_beat(make_alloc(200, 100));
		live_off.delete();
		live_ord.delete();
		queue_beat(make_free(0, 10));

		for (ph = 0; ph < 3; ph++) begin
			while (pending_reqs.size() != 0)
				@(posedge clk);
			send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 81 : 0;
			recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 10 : 0;
			for (i = 0; i < 380; i++)
				queue_beat(($urandom_range(0, 99) < 55) ? rand_alloc() : rand_free());
		end
		while (pending_reqs.size() != 0)
			@(posedge clk);
		stim_done = 1'b1;
	end

	// Note whether the block took the request beat at this edge
	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
	end

	// Driver: present the head beat, hold it until taken, idle at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken)
				void'(pending_reqs.pop_front());
			if (!req_valid || req_taken) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_item <= pending_reqs[0];
				end else
					req_valid <= 1'b0;
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Monitor: compare every accepted result beat with the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_rsp;
		cycles <= cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, rsp_item);
				errors <= errors + 1;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp_item !== exp_rsp) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_rsp, rsp_item);
					errors <= errors + 1;
				end
			end
		end
	end

	// Finish: drain, let the block settle, then report
	initial begin
		while (!(stim_done && expected_rsps.size() == 0))
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("buddy_block_allocator_tb: PASS");
		else
			$display("buddy_block_allocator_tb: FAIL");
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("buddy_block_allocator_tb: FAIL");
			$finish;
		end
	end
endmodule
